// File: sv/tvbm_pkg.sv
// tvbm_pkg: shared types, register indexes and arithmetic helpers for the
// TVB minmod slope limiter. No dependencies.
package tvbm_pkg;

   localparam int CSR_IDX_W = 1;
   localparam int THR_W     = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_MOD_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHEME_ORDER  = 1'd1;

   localparam logic [1:0] ORDER_2     = 2'd2;
   localparam logic [1:0] ORDER_3     = 2'd3;
   localparam logic [1:0] ORDER_RESET = 2'd3;

   // floor(n/3) = (n * RECIP3) >> SHIFT3, floor(n/15) = (n * RECIP15) >> SHIFT15,
   // exact for n below 2^31
   localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;
   localparam int          SHIFT3  = 33;
   localparam logic [31:0] RECIP15 = 32'h8888_8889;
   localparam int          SHIFT15 = 35;

   typedef struct packed {
      logic [1:0]         variable;
      logic signed [31:0] cell_mean;
      logic signed [31:0] left_border;
      logic signed [31:0] right_border;
      logic               first_cell;
      logic               last_cell;
   } req_type;

   typedef struct packed {
      logic [1:0]         variable_out;
      logic signed [31:0] left_mod;
      logic signed [31:0] right_mod;
      logic signed [31:0] limited_left;
      logic signed [31:0] limited_right;
      logic signed [31:0] first_coef;
      logic signed [31:0] second_coef;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0] mod_threshold;
      logic [1:0]       scheme_order;
   } csr_type;

   // one cell to be limited: mean, raw deviations, neighbor differences
   typedef struct packed {
      logic [1:0]         variable;
      logic signed [31:0] mean;
      logic signed [31:0] ldev;
      logic signed [31:0] rdev;
      logic signed [32:0] nb_diff;
      logic signed [32:0] nc_diff;
      logic               last;
   } emit_type;

   typedef struct packed {
      logic [1:0]         variable;
      logic signed [31:0] mean;
      logic signed [31:0] lm;
      logic signed [31:0] rm;
      logic               last;
   } lim_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// File: sv/tvb_minmod_slope_limiter_top.sv
// tvb_minmod_slope_limiter_top: top level with request register and CSRs.
// Depends on tvbm_pkg, tvbm_window, tvbm_limit, tvbm_coef.
//
// Streams cells in domain order, one beat per variable per cell, and returns
// the TVB minmod limited deviations, limited border values and coefficient
// corrections of a cell once the next cell of that variable has arrived; a
// last cell (or a cell flushed by a new first cell) is reported at once. One
// request beat is taken per cycle unless the results stall; a beat that
// produces two result beats fills the window's two-entry result queue, so the
// request side stalls until one of them has left. Results pass the request
// register, window queue, limiter, rounding prep, multiply and result
// register. Beats with a variable index at or above NUM_VARS are dropped. The
// user must write CSRs only while the block is idle; the block does not enforce it.
module tvb_minmod_slope_limiter_top import tvbm_pkg::*; #(
   parameter int NUM_VARS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   csr_type csr_ff, csr_in;
   req_type in_data_ff, in_data_in;
   logic    in_v_ff, in_v_in;
   logic    win_ready;

   emit_type em_item;
   logic     em_valid, em_ready;
   lim_type  lim_item;
   logic     lim_valid, lim_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MOD_THRESHOLD: csr_in.mod_threshold = csr_wdata;
            CSR_SCHEME_ORDER:  csr_in.scheme_order  = csr_wdata[1:0];
         endcase
      end
   end

   assign req_ready  = !in_v_ff || win_ready;
   assign in_v_in    = req_ready ? req_valid : in_v_ff;
   assign in_data_in = (req_valid && req_ready) ? req_data : in_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.mod_threshold <= '0;
         csr_ff.scheme_order  <= ORDER_RESET;
         in_v_ff              <= 1'b0;
      end else begin
         csr_ff  <= csr_in;
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   tvbm_window #(.NUM_VARS(NUM_VARS)) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .in_ready  (win_ready),
      .in_item   (in_data_ff),
      .out_valid (em_valid),
      .out_ready (em_ready),
      .out_item  (em_item)
   );

   tvbm_limit u_limit (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (em_valid),
      .in_ready  (em_ready),
      .in_item   (em_item),
      .out_valid (lim_valid),
      .out_ready (lim_ready),
      .out_item  (lim_item)
   );

   tvbm_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (lim_valid),
      .in_ready  (lim_ready),
      .in_item   (lim_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_data)
   );

endmodule

// File: sv/tvbm_window.sv
// tvbm_window: per-variable three-cell window and two-entry result queue.
// Depends on tvbm_pkg.
module tvbm_window import tvbm_pkg::*; #(
   parameter int NUM_VARS = 3
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output emit_type out_item
);

   localparam int VIW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

   logic signed [31:0] held_mean_ff [NUM_VARS];
   logic signed [31:0] prev_mean_ff [NUM_VARS];
   logic signed [31:0] held_ldev_ff [NUM_VARS];
   logic signed [31:0] held_rdev_ff [NUM_VARS];
   logic [NUM_VARS-1:0] held_first_ff, held_first_in;
   logic [NUM_VARS-1:0] held_valid_ff, held_valid_in;

   emit_type job0_ff, job0_in, job1_ff, job1_in;
   logic     job0_v_ff, job0_v_in, job1_v_ff, job1_v_in;

   logic               var_ok, empty_next, load, st_we, chain, hv, hf;
   logic [VIW-1:0]     vidx;
   logic signed [31:0] held, prev, ldev, rdev;
   logic signed [32:0] d_next, d_prev, self_diff;

   assign var_ok = int'(in_item.variable) < NUM_VARS;
   assign vidx   = var_ok ? VIW'(in_item.variable) : '0;
   assign hv     = held_valid_ff[vidx];
   assign hf     = held_first_ff[vidx];
   assign held   = held_mean_ff[vidx];
   assign prev   = prev_mean_ff[vidx];

   assign ldev = sat32({in_item.cell_mean[31], in_item.cell_mean}
                     - {in_item.left_border[31], in_item.left_border});
   assign rdev = sat32({in_item.right_border[31], in_item.right_border}
                     - {in_item.cell_mean[31], in_item.cell_mean});
   assign d_next = {in_item.cell_mean[31], in_item.cell_mean} - {held[31], held};
   assign d_prev = {held[31], held} - {prev[31], prev};

   // held cell continues as an interior cell
   assign chain     = hv && !in_item.first_cell;
   assign self_diff = chain ? d_next : '0;

   assign empty_next = (!job0_v_ff && !job1_v_ff) || (out_ready && (job0_v_ff ^ job1_v_ff));
   assign in_ready   = empty_next;
   assign load       = in_valid && empty_next;
   assign st_we      = load && var_ok;

   assign out_valid = job0_v_ff || job1_v_ff;
   assign out_item  = job0_v_ff ? job0_ff : job1_ff;

   always_comb begin
      job0_v_in = job0_v_ff;
      job1_v_in = job1_v_ff;
      job0_in   = job0_ff;
      job1_in   = job1_ff;
      if (load) begin
         job0_v_in        = var_ok && hv;
         job1_v_in        = var_ok && in_item.last_cell;
         job0_in.variable = in_item.variable;
         job0_in.mean     = held;
         job0_in.ldev     = held_ldev_ff[vidx];
         job0_in.rdev     = held_rdev_ff[vidx];
         job0_in.nb_diff  = chain ? d_next : (hf ? '0 : d_prev);
         job0_in.nc_diff  = hf ? self_diff : d_prev;
         job0_in.last     = in_item.first_cell;
         job1_in.variable = in_item.variable;
         job1_in.mean     = in_item.cell_mean;
         job1_in.ldev     = ldev;
         job1_in.rdev     = rdev;
         job1_in.nb_diff  = self_diff;
         job1_in.nc_diff  = self_diff;
         job1_in.last     = 1'b1;
      end else if (out_ready && out_valid) begin
         if (job0_v_ff) begin
            job0_v_in = 1'b0;
         end else begin
            job1_v_in = 1'b0;
         end
      end
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      if (st_we) begin
         held_valid_in[vidx] = !in_item.last_cell;
         held_first_in[vidx] = !chain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job0_v_ff     <= 1'b0;
         job1_v_ff     <= 1'b0;
         held_valid_ff <= '0;
         held_first_ff <= '0;
      end else begin
         job0_v_ff     <= job0_v_in;
         job1_v_ff     <= job1_v_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
      end
   end

   always_ff @(posedge clock) begin
      job0_ff <= job0_in;
      job1_ff <= job1_in;
      if (st_we && !in_item.last_cell) begin
         held_mean_ff[vidx] <= in_item.cell_mean;
         held_ldev_ff[vidx] <= ldev;
         held_rdev_ff[vidx] <= rdev;
         if (chain) begin
            prev_mean_ff[vidx] <= held;
         end
      end
   end

endmodule

// File: sv/tvbm_limit.sv
// tvbm_limit: TVB minmod of both deviations of one cell, registered.
// Depends on tvbm_pkg.
module tvbm_limit import tvbm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  csr_type  csr,
   input  logic     in_valid,
   output logic     in_ready,
   input  emit_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output lim_type  out_item
);

   function automatic logic signed [31:0] tvb_limit(
      input logic signed [31:0] a,
      input logic signed [32:0] b,
      input logic signed [32:0] c,
      input logic [THR_W-1:0]   thr
   );
      logic [32:0]        ma, mb, mc, m;
      logic               same;
      logic signed [32:0] r;
      ma   = a[31] ? (33'd0 - {a[31], a}) : {1'b0, a};
      mb   = b[32] ? (33'd0 - b) : b;
      mc   = c[32] ? (33'd0 - c) : c;
      same = (a != '0) && (b != '0) && (c != '0) && (a[31] == b[32]) && (a[31] == c[32]);
      m    = ma;
      if (mb < m) begin
         m = mb;
      end
      if (mc < m) begin
         m = mc;
      end
      r = a[31] ? (33'd0 - m) : m;
      if (ma <= {2'b00, thr}) begin
         return a;
      end else if (!same) begin
         return '0;
      end
      return r[31:0];
   endfunction

   lim_type lim_ff, lim_in;
   logic    lim_v_ff, lim_v_in;

   assign in_ready  = !lim_v_ff || out_ready;
   assign out_valid = lim_v_ff;
   assign out_item  = lim_ff;

   always_comb begin
      lim_v_in = in_ready ? in_valid : lim_v_ff;
      lim_in   = lim_ff;
      if (in_valid && in_ready) begin
         lim_in.variable = in_item.variable;
         lim_in.mean     = in_item.mean;
         lim_in.lm       = tvb_limit(in_item.ldev, in_item.nb_diff, in_item.nc_diff,
                                     csr.mod_threshold);
         lim_in.rm       = tvb_limit(in_item.rdev, in_item.nb_diff, in_item.nc_diff,
                                     csr.mod_threshold);
         lim_in.last     = in_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_v_ff <= 1'b0;
      end else begin
         lim_v_ff <= lim_v_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
   end

endmodule

// File: sv/tvbm_coef.sv
// tvbm_coef: limited borders, rounded coefficient corrections and result register.
// Depends on tvbm_pkg.
module tvbm_coef import tvbm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    in_valid,
   output logic    in_ready,
   input  lim_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   typedef struct packed {
      logic [1:0]         variable;
      logic signed [31:0] left_mod;
      logic signed [31:0] right_mod;
      logic signed [31:0] limited_left;
      logic signed [31:0] limited_right;
      logic               last;
      logic [30:0]        n1;
      logic               n1_neg;
      logic               n1_use;
      logic [30:0]        n2;
      logic               n2_neg;
      logic               n2_use;
   } pre_type;

   pre_type pre_ff, pre_in;
   logic    pre_v_ff, pre_v_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_v_ff, rsp_v_in;
   logic    pre_ready;

   logic signed [32:0] sum, dif;
   logic [32:0]        lm_r;
   logic [33:0]        sum_r, dif_r;

   logic [62:0]         p1, p2;
   logic [62-SHIFT3:0]  q1;
   logic [62-SHIFT15:0] q2;
   logic [31:0]         q1x, q2x;

   assign pre_ready = !rsp_v_ff || out_ready;
   assign in_ready  = !pre_v_ff || pre_ready;
   assign out_valid = rsp_v_ff;
   assign out_item  = rsp_ff;

   // magnitude plus half the divisor, pre-shifted so only /3 or /15 remains
   assign sum   = {in_item.lm[31], in_item.lm} + {in_item.rm[31], in_item.rm};
   assign dif   = {in_item.rm[31], in_item.rm} - {in_item.lm[31], in_item.lm};
   assign lm_r  = in_item.lm[31] ? (33'd3 - {in_item.lm[31], in_item.lm})
                                 : ({1'b0, in_item.lm} + 33'd3);
   assign sum_r = sum[32] ? (34'd6 - {sum[32], sum}) : ({1'b0, sum} + 34'd6);
   assign dif_r = dif[32] ? (34'd30 - {dif[32], dif}) : ({1'b0, dif} + 34'd30);

   always_comb begin
      pre_v_in = in_ready ? in_valid : pre_v_ff;
      pre_in   = pre_ff;
      if (in_valid && in_ready) begin
         pre_in.variable      = in_item.variable;
         pre_in.left_mod      = in_item.lm;
         pre_in.right_mod     = in_item.rm;
         pre_in.limited_left  = sat32({in_item.mean[31], in_item.mean}
                                    - {in_item.lm[31], in_item.lm});
         pre_in.limited_right = sat32({in_item.mean[31], in_item.mean}
                                    + {in_item.rm[31], in_item.rm});
         pre_in.last          = in_item.last;
         pre_in.n2            = dif_r[32:2];
         pre_in.n2_neg        = dif[32];
         pre_in.n2_use        = (csr.scheme_order == ORDER_3);
         unique case (csr.scheme_order)
            ORDER_2: begin
               pre_in.n1     = lm_r[31:1];
               pre_in.n1_neg = in_item.lm[31];
               pre_in.n1_use = 1'b1;
            end
            ORDER_3: begin
               pre_in.n1     = sum_r[32:2];
               pre_in.n1_neg = sum[32];
               pre_in.n1_use = 1'b1;
            end
            default: begin
               pre_in.n1     = sum_r[32:2];
               pre_in.n1_neg = 1'b0;
               pre_in.n1_use = 1'b0;
            end
         endcase
      end
   end

   assign p1  = 63'(pre_ff.n1) * 63'(RECIP3);
   assign p2  = 63'(pre_ff.n2) * 63'(RECIP15);
   assign q1  = p1[62:SHIFT3];
   assign q2  = p2[62:SHIFT15];
   assign q1x = 32'(q1);
   assign q2x = 32'(q2);

   always_comb begin
      rsp_v_in = pre_ready ? pre_v_ff : rsp_v_ff;
      rsp_in   = rsp_ff;
      if (pre_v_ff && pre_ready) begin
         rsp_in.variable_out  = pre_ff.variable;
         rsp_in.left_mod      = pre_ff.left_mod;
         rsp_in.right_mod     = pre_ff.right_mod;
         rsp_in.limited_left  = pre_ff.limited_left;
         rsp_in.limited_right = pre_ff.limited_right;
         rsp_in.first_coef    = !pre_ff.n1_use ? '0 :
                                (pre_ff.n1_neg ? (32'd0 - q1x) : q1x);
         rsp_in.second_coef   = !pre_ff.n2_use ? '0 :
                                (pre_ff.n2_neg ? (32'd0 - q2x) : q2x);
         rsp_in.last          = pre_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         pre_v_ff <= pre_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: sv/tvbm_checker.sv
// tvbm_checker: port-level assertions for the slope limiter, bound to the top.
// Depends on tvbm_pkg and tvb_minmod_slope_limiter_top.
module tvbm_checker import tvbm_pkg::*; #(
   parameter int NUM_VARS = 3
) (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_req_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request side not ready after reset");

   a_var_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.variable_out) < NUM_VARS)
      else $error("result for a dropped variable index");

   a_zero_coef: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.left_mod == '0 && rsp_data.right_mod == '0
      |-> rsp_data.first_coef == '0 && rsp_data.second_coef == '0)
      else $error("nonzero correction for zero deviations");

endmodule

bind tvb_minmod_slope_limiter_top tvbm_checker #(.NUM_VARS(NUM_VARS)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
